// ===== rtl/core/dlle_pkg.sv =====
// shared constants, types and codes for the dual linked list engine
`timescale 1ns / 1ps
`default_nettype none
package dlle_pkg;

	// pool geometry and value width
	localparam int POOL_SIZE   = 32;
	localparam int VALUE_BITS  = 32;
	localparam int MAX_RESULTS = 32;

	localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CNT_W = $clog2(POOL_SIZE + 1);
	localparam int VAL_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	// fixed field widths
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;
	localparam int DATA_W   = 32;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [VAL_W-1:0]    val_t;

	// command codes
	localparam cmd_t CMD_INS_FRONT = 3'd0;
	localparam cmd_t CMD_INS_BACK  = 3'd1;
	localparam cmd_t CMD_SEARCH    = 3'd2;
	localparam cmd_t CMD_REMOVE    = 3'd3;
	localparam cmd_t CMD_READ      = 3'd4;
	localparam cmd_t CMD_CAT       = 3'd5;

	// status codes
	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_NOTFOUND = 2'd1;
	localparam status_t STATUS_FULL     = 2'd2;
	localparam status_t STATUS_EMPTY    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_LINK,
		ST_RD,
		ST_CMP,
		ST_CAT,
		ST_EMIT
	} dlle_state_t;

	// free map control and status
	typedef struct packed {
		logic clr;
		logic step;
		logic take;
		logic give;
		idx_t give_idx;
	} fm_ctl_t;

	typedef struct packed {
		logic hit;
		idx_t idx;
	} fm_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/dlle_req_if.sv =====
// command channel of the dual linked list engine
`timescale 1ns / 1ps
`default_nettype none
interface dlle_req_if;
	logic                                valid;
	logic                                ready;
	logic [dlle_pkg::CMD_W-1:0]          cmd;
	logic                                list_sel;
	logic signed [dlle_pkg::DATA_W-1:0]  value_in;

	modport source (output valid, output cmd, output list_sel, output value_in, input ready);
	modport sink (input valid, input cmd, input list_sel, input value_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dlle_rsp_if.sv =====
// result channel of the dual linked list engine
`timescale 1ns / 1ps
`default_nettype none
interface dlle_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [dlle_pkg::STATUS_W-1:0]       status;
	logic signed [dlle_pkg::DATA_W-1:0]  value_out;
	logic [dlle_pkg::COUNT_W-1:0]        count;
	logic                                last;

	modport source (output valid, output status, output value_out, output count, output last,
		input ready);
	modport sink (input valid, input status, input value_out, input count, input last,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dlle_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module dlle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/dlle_free_map.sv =====
// free node map with a one-bit-per-cycle scan for the lowest free node
`timescale 1ns / 1ps
`default_nettype none
module dlle_free_map (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dlle_pkg::fm_ctl_t ctl,
	output dlle_pkg::fm_stat_t     stat
);

	logic [dlle_pkg::POOL_SIZE-1:0] free_q;
	dlle_pkg::idx_t                 scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			scan_q <= '0;
		end else begin
			if (ctl.clr) begin
				scan_q <= '0;
			end else if (ctl.step) begin
				scan_q <= scan_q + dlle_pkg::IDX_W'(1);
			end
			if (ctl.take) begin
				free_q[scan_q] <= 1'b0;
			end
			if (ctl.give) begin
				free_q[ctl.give_idx] <= 1'b1;
			end
		end
	end

	assign stat.hit = free_q[scan_q];
	assign stat.idx = scan_q;

endmodule
`default_nettype wire

// ===== rtl/core/dual_linked_list_engine.sv =====
// top level of the dual linked list engine: sequencer, list registers, node memories
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+------------------------------------------
//  req     | in  | valid / ready  | cmd[2:0], list_sel, value_in[31:0] signed
//  rsp     | out | valid / ready  | status[1:0], value_out[31:0], count[5:0], last
//
// one command at a time; req.ready is high only while the sequencer is idle
// insert: a free map scan probes nodes from the lowest index up (up to POOL_SIZE),
// then a link step for a back insert into a non-empty list
// search/remove: each node walked is read from node memory, then compared
// read out: one word per node walked; cat: one splice; rsp back pressure adds stalls
// a finished word waits in the output register while the next command is taken
// reset clears lists and free map at once; node memories need no clearing
`timescale 1ns / 1ps
`default_nettype none
module dual_linked_list_engine (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dlle_req_if.sink   req,
	dlle_rsp_if.source rsp
);

	// sequencer
	dlle_pkg::dlle_state_t state_q, state_nx;

	// list registers (one entry per list)
	dlle_pkg::idx_t head_q [2];
	dlle_pkg::idx_t tail_q [2];
	dlle_pkg::cnt_t cnt_q  [2];

	// latched command and walk registers
	dlle_pkg::cmd_t    cmd_q;
	logic              sel_q;
	dlle_pkg::val_t    val_q;
	dlle_pkg::status_t st_q;
	dlle_pkg::idx_t    cur_q;
	dlle_pkg::idx_t    prev_q;
	dlle_pkg::idx_t    node_q;
	dlle_pkg::cnt_t    steps_q;

	// output register
	logic                          rsp_vld_q;
	dlle_pkg::status_t             rsp_status_q;
	logic [dlle_pkg::DATA_W-1:0]   rsp_value_q;
	logic [dlle_pkg::COUNT_W-1:0]  rsp_count_q;
	logic                          rsp_last_q;

	// node memories
	logic           vw_en;
	dlle_pkg::idx_t vw_addr;
	dlle_pkg::val_t vw_data;
	dlle_pkg::val_t rd_val;
	logic           nw_en;
	dlle_pkg::idx_t nw_addr;
	dlle_pkg::idx_t nw_data;
	dlle_pkg::idx_t rd_next;

	// free map
	dlle_pkg::fm_ctl_t  fm_ctl;
	dlle_pkg::fm_stat_t fm_stat;

	// helpers
	logic                            req_fire;
	logic                            emit_ok;
	dlle_pkg::cnt_t                  cnt_s, cnt_o, cnt_req;
	dlle_pkg::idx_t                  head_s, head_o, tail_s, tail_o;
	dlle_pkg::cnt_t                  steps_nx;
	logic                            walk_end;
	logic                            rd_last;
	logic                            match;
	logic                            pool_full;
	logic [dlle_pkg::CNT_W:0]        used_sum;

	// output register load
	logic                            rsp_ld;
	dlle_pkg::status_t               ld_status;
	logic [dlle_pkg::DATA_W-1:0]     ld_value;
	logic                            ld_last;

	dlle_ram #(
		.WIDTH (dlle_pkg::VAL_W),
		.DEPTH (dlle_pkg::POOL_SIZE)
	) u_val_ram (
		.clk   (clk),
		.we    (vw_en),
		.waddr (vw_addr),
		.wdata (vw_data),
		.raddr (cur_q),
		.rdata (rd_val)
	);

	dlle_ram #(
		.WIDTH (dlle_pkg::IDX_W),
		.DEPTH (dlle_pkg::POOL_SIZE)
	) u_next_ram (
		.clk   (clk),
		.we    (nw_en),
		.waddr (nw_addr),
		.wdata (nw_data),
		.raddr (cur_q),
		.rdata (rd_next)
	);

	dlle_free_map u_free_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fm_ctl),
		.stat   (fm_stat)
	);

	assign req.ready = (state_q == dlle_pkg::ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign emit_ok   = !rsp_vld_q || rsp.ready;

	assign cnt_s   = cnt_q[sel_q];
	assign cnt_o   = cnt_q[~sel_q];
	assign head_s  = head_q[sel_q];
	assign head_o  = head_q[~sel_q];
	assign tail_s  = tail_q[sel_q];
	assign tail_o  = tail_q[~sel_q];
	assign cnt_req = cnt_q[req.list_sel];

	// pool is full when both lists together hold every node
	assign used_sum  = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
	assign pool_full = (used_sum == (dlle_pkg::CNT_W + 1)'(dlle_pkg::POOL_SIZE));

	// the shared compare: each node value read back against the latched value
	assign match    = (rd_val == val_q);
	assign steps_nx = steps_q + dlle_pkg::CNT_W'(1);
	assign walk_end = (steps_nx == cnt_s);
	assign rd_last  = walk_end || (int'(steps_nx) == dlle_pkg::MAX_RESULTS);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dlle_pkg::ST_IDLE: begin
				if (req_fire) begin
					case (req.cmd)
						dlle_pkg::CMD_INS_FRONT,
						dlle_pkg::CMD_INS_BACK: begin
							state_nx = pool_full ? dlle_pkg::ST_EMIT : dlle_pkg::ST_ALLOC;
						end
						dlle_pkg::CMD_SEARCH,
						dlle_pkg::CMD_REMOVE,
						dlle_pkg::CMD_READ: begin
							state_nx = (cnt_req == '0) ? dlle_pkg::ST_EMIT : dlle_pkg::ST_RD;
						end
						dlle_pkg::CMD_CAT: state_nx = dlle_pkg::ST_CAT;
						default: state_nx = dlle_pkg::ST_IDLE;
					endcase
				end
			end
			dlle_pkg::ST_ALLOC: begin
				if (fm_stat.hit) begin
					if (cmd_q == dlle_pkg::CMD_INS_BACK && cnt_s != '0) begin
						state_nx = dlle_pkg::ST_LINK;
					end else begin
						state_nx = dlle_pkg::ST_EMIT;
					end
				end
			end
			dlle_pkg::ST_LINK: state_nx = dlle_pkg::ST_EMIT;
			dlle_pkg::ST_RD:   state_nx = dlle_pkg::ST_CMP;
			dlle_pkg::ST_CMP: begin
				if (cmd_q == dlle_pkg::CMD_READ) begin
					if (emit_ok) begin
						state_nx = rd_last ? dlle_pkg::ST_IDLE : dlle_pkg::ST_RD;
					end
				end else if (match || walk_end) begin
					state_nx = dlle_pkg::ST_EMIT;
				end else begin
					state_nx = dlle_pkg::ST_RD;
				end
			end
			dlle_pkg::ST_CAT: state_nx = dlle_pkg::ST_EMIT;
			dlle_pkg::ST_EMIT: begin
				if (emit_ok) begin
					state_nx = dlle_pkg::ST_IDLE;
				end
			end
			default: state_nx = dlle_pkg::ST_IDLE;
		endcase
	end

	// memory writes, free map control, output register load
	always_comb begin
		vw_en     = 1'b0;
		vw_addr   = fm_stat.idx;
		vw_data   = val_q;
		nw_en     = 1'b0;
		nw_addr   = tail_s;
		nw_data   = node_q;
		fm_ctl    = '0;
		rsp_ld    = 1'b0;
		ld_status = st_q;
		ld_value  = '0;
		ld_last   = 1'b1;
		case (state_q)
			dlle_pkg::ST_IDLE: fm_ctl.clr = req_fire;
			dlle_pkg::ST_ALLOC: begin
				if (fm_stat.hit) begin
					fm_ctl.take = 1'b1;
					vw_en       = 1'b1;
					nw_en       = 1'b1;
					nw_addr     = fm_stat.idx;
					// front insert into a non-empty list points at the old head
					nw_data     = (cmd_q == dlle_pkg::CMD_INS_FRONT && cnt_s != '0) ?
						head_s : '0;
				end else begin
					fm_ctl.step = 1'b1;
				end
			end
			dlle_pkg::ST_LINK: nw_en = 1'b1;
			dlle_pkg::ST_CMP: begin
				if (cmd_q == dlle_pkg::CMD_READ) begin
					rsp_ld    = emit_ok;
					ld_status = dlle_pkg::STATUS_OK;
					ld_value  = dlle_pkg::DATA_W'(rd_val);
					ld_last   = rd_last;
				end else if (match && cmd_q == dlle_pkg::CMD_REMOVE) begin
					fm_ctl.give     = 1'b1;
					fm_ctl.give_idx = cur_q;
					// unlink from the predecessor unless the match is the head
					if (steps_q != '0) begin
						nw_en   = 1'b1;
						nw_addr = prev_q;
						nw_data = rd_next;
					end
				end
			end
			dlle_pkg::ST_CAT: begin
				// splice the other list behind our tail
				nw_en   = (cnt_o != '0) && (cnt_s != '0);
				nw_data = head_o;
			end
			dlle_pkg::ST_EMIT: rsp_ld = emit_ok;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dlle_pkg::ST_IDLE;
			head_q[0] <= '0;
			head_q[1] <= '0;
			tail_q[0] <= '0;
			tail_q[1] <= '0;
			cnt_q[0]  <= '0;
			cnt_q[1]  <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (rsp_ld) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			case (state_q)
				dlle_pkg::ST_ALLOC: begin
					if (fm_stat.hit) begin
						if (cnt_s == '0) begin
							head_q[sel_q] <= fm_stat.idx;
							tail_q[sel_q] <= fm_stat.idx;
							cnt_q[sel_q]  <= cnt_s + dlle_pkg::CNT_W'(1);
						end else if (cmd_q == dlle_pkg::CMD_INS_FRONT) begin
							head_q[sel_q] <= fm_stat.idx;
							cnt_q[sel_q]  <= cnt_s + dlle_pkg::CNT_W'(1);
						end
					end
				end
				dlle_pkg::ST_LINK: begin
					tail_q[sel_q] <= node_q;
					cnt_q[sel_q]  <= cnt_s + dlle_pkg::CNT_W'(1);
				end
				dlle_pkg::ST_CMP: begin
					if (cmd_q == dlle_pkg::CMD_REMOVE && match) begin
						if (steps_q == '0) begin
							head_q[sel_q] <= rd_next;
						end
						if (walk_end) begin
							tail_q[sel_q] <= prev_q;
						end
						cnt_q[sel_q] <= cnt_s - dlle_pkg::CNT_W'(1);
					end
				end
				dlle_pkg::ST_CAT: begin
					if (cnt_o != '0) begin
						if (cnt_s == '0) begin
							head_q[sel_q] <= head_o;
						end
						tail_q[sel_q]  <= tail_o;
						cnt_q[sel_q]   <= cnt_s + cnt_o;
						cnt_q[~sel_q]  <= '0;
						head_q[~sel_q] <= '0;
						tail_q[~sel_q] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// command, walk and output payload registers
	always_ff @(posedge clk) begin
		if (rsp_ld) begin
			rsp_status_q <= ld_status;
			rsp_value_q  <= ld_value;
			rsp_count_q  <= dlle_pkg::COUNT_W'(cnt_s);
			rsp_last_q   <= ld_last;
		end

		case (state_q)
			dlle_pkg::ST_IDLE: begin
				if (req_fire) begin
					cmd_q   <= req.cmd;
					sel_q   <= req.list_sel;
					val_q   <= dlle_pkg::VAL_W'(req.value_in);
					cur_q   <= head_q[req.list_sel];
					prev_q  <= '0;
					steps_q <= '0;
					if ((req.cmd == dlle_pkg::CMD_INS_FRONT ||
						req.cmd == dlle_pkg::CMD_INS_BACK) && pool_full) begin
						st_q <= dlle_pkg::STATUS_FULL;
					end else if ((req.cmd == dlle_pkg::CMD_SEARCH ||
						req.cmd == dlle_pkg::CMD_REMOVE ||
						req.cmd == dlle_pkg::CMD_READ) && cnt_req == '0) begin
						st_q <= dlle_pkg::STATUS_EMPTY;
					end else begin
						st_q <= dlle_pkg::STATUS_OK;
					end
				end
			end
			dlle_pkg::ST_ALLOC: begin
				if (fm_stat.hit) begin
					node_q <= fm_stat.idx;
				end
			end
			dlle_pkg::ST_CMP: begin
				if (cmd_q == dlle_pkg::CMD_READ) begin
					if (emit_ok) begin
						cur_q   <= rd_next;
						steps_q <= steps_nx;
					end
				end else if (match) begin
					st_q <= dlle_pkg::STATUS_OK;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= rd_next;
					steps_q <= steps_nx;
					if (walk_end) begin
						st_q <= dlle_pkg::STATUS_NOTFOUND;
					end
				end
			end
			dlle_pkg::ST_CAT: begin
				if (cnt_s == '0 && cnt_o == '0) begin
					st_q <= dlle_pkg::STATUS_EMPTY;
				end else begin
					st_q <= dlle_pkg::STATUS_OK;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.value_out = rsp_value_q;
	assign rsp.count     = rsp_count_q;
	assign rsp.last      = rsp_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/dlle_checker.sv =====
// port level checks of the dual linked list engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dlle_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              req_valid,
	input wire logic                              req_ready,
	input wire logic [dlle_pkg::CMD_W-1:0]        req_cmd,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [dlle_pkg::STATUS_W-1:0]     rsp_status,
	input wire logic [dlle_pkg::COUNT_W-1:0]      rsp_count,
	input wire logic                              rsp_last
);

	// a stalled word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped under stall");

	// only read out makes several words, and all but the last are ok
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == dlle_pkg::STATUS_OK)
		else $error("non-final word with error status");

	// an empty list reports a zero count
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == dlle_pkg::STATUS_EMPTY |-> rsp_count == '0)
		else $error("empty status with nonzero count");

	// a known command keeps the block busy for at least the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd <= dlle_pkg::CMD_CAT |=> !req_ready)
		else $error("ready right after a command was taken");

endmodule

bind dual_linked_list_engine dlle_checker u_dlle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_cmd    (req.cmd),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.count),
	.rsp_last   (rsp.last)
);
`default_nettype wire
